// ===== rtl/core/twsbm_pkg.sv =====
// Shared constants and types for the three-wire serial byte master.
package twsbm_pkg;

  localparam int unsigned BYTE_BITS_DEF = 8;
  localparam int unsigned FIELD_W       = 8;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned CFG_IDX_W     = 1;

  localparam logic [FIELD_W-1:0] READ_FLAG_RST  = 8'h01;
  localparam logic [FIELD_W-1:0] WRITE_FLAG_RST = 8'h00;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK        = 2'd0,
    MODE_START_READ  = 2'd1,
    MODE_START_WRITE = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_READ_FLAG  = 1'd0,
    CFG_WRITE_FLAG = 1'd1
  } cfg_idx_e;

endpackage

// ===== rtl/core/three_wire_serial_byte_master_unit.sv =====
// Top level of the three-wire serial byte master: bus sequencer and result register.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------------------
//   in       | input     | in_valid_i/in_stall_o   | mode, command_address, write_data, line_in
//   out      | output    | out_valid_o/out_stall_i | enable, clock, line, drive, busy, done, byte
//   cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each beat is handled combinationally: the state update and the line levels are computed
// from the accepted beat and land in the result register at the same edge.
// One beat per cycle is sustained; in_stall_o rises only while a held result is stalled.
// rst_ni clears the sequencer state, the flags to their defaults and the result valid.
// A transaction spans 4*BYTE_BITS tick beats after its start beat.
module three_wire_serial_byte_master_unit #(
  parameter int unsigned BYTE_BITS = twsbm_pkg::BYTE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [twsbm_pkg::MODE_W-1:0]      mode_i,
  input  logic [twsbm_pkg::FIELD_W-1:0]     command_address_i,
  input  logic [twsbm_pkg::FIELD_W-1:0]     write_data_i,
  input  logic                              line_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              enable_out_o,
  output logic                              clock_out_o,
  output logic                              line_out_o,
  output logic                              line_drive_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic [twsbm_pkg::FIELD_W-1:0]     read_byte_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [twsbm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [twsbm_pkg::FIELD_W-1:0]     cfg_data_i
);

  localparam int unsigned FW       = twsbm_pkg::FIELD_W;
  localparam int unsigned FRAME    = 2 * BYTE_BITS;
  localparam int unsigned PH_W     = $clog2(4 * BYTE_BITS + 1);
  localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(4 * BYTE_BITS);
  localparam logic [PH_W-1:0] RX_PHASE   = PH_W'(2 * BYTE_BITS);

  logic [FW-1:0]        read_flag_q, write_flag_q;
  logic [PH_W-1:0]      phase_q, phase_d, phase_inc;
  logic                 is_read_q, is_read_d;
  logic [FRAME-1:0]     send_q, send_d;
  logic [BYTE_BITS-1:0] recv_q, recv_d;
  logic [BYTE_BITS-1:0] last_q, last_d;
  logic                 enable_q, enable_d;
  logic                 clock_q, clock_d;
  logic                 done_d, drive_d, level_d;

  logic                 out_valid_q;
  logic                 enable_res_q, clock_res_q, line_res_q, drive_res_q, done_res_q;
  logic [FW-1:0]        byte_res_q;

  logic                 in_acc;
  logic [BYTE_BITS+FW-1:0] addr_wide, flag_wide, data_wide, last_wide;
  logic [BYTE_BITS-1:0]    cmd_w, data_w;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign addr_wide = {{BYTE_BITS{1'b0}}, command_address_i};
  assign flag_wide = {{BYTE_BITS{1'b0}},
                      (mode_i == twsbm_pkg::MODE_START_READ) ? read_flag_q : write_flag_q};
  assign data_wide = {{BYTE_BITS{1'b0}}, write_data_i};
  assign cmd_w     = addr_wide[BYTE_BITS-1:0] | flag_wide[BYTE_BITS-1:0];
  assign data_w    = data_wide[BYTE_BITS-1:0];
  assign phase_inc = phase_q + PH_W'(1);

  always_comb begin
    phase_d   = phase_q;
    is_read_d = is_read_q;
    send_d    = send_q;
    recv_d    = recv_q;
    last_d    = last_q;
    enable_d  = enable_q;
    clock_d   = clock_q;
    done_d    = 1'b0;
    unique case (twsbm_pkg::mode_e'(mode_i))
      twsbm_pkg::MODE_START_READ, twsbm_pkg::MODE_START_WRITE: begin
        if (!enable_q) begin
          is_read_d = (mode_i == twsbm_pkg::MODE_START_READ);
          send_d    = {cmd_w, is_read_d ? {BYTE_BITS{1'b0}} : data_w};
          recv_d    = '0;
          phase_d   = '0;
          enable_d  = 1'b1;
          clock_d   = 1'b0;
        end
      end
      twsbm_pkg::MODE_TICK: begin
        if (enable_q) begin
          phase_d = phase_inc;
          if (phase_inc[0]) begin
            if (is_read_q && phase_q >= RX_PHASE) begin
              recv_d = {recv_q[BYTE_BITS-2:0], line_in_i};
            end
            clock_d = 1'b1;
          end else begin
            clock_d = 1'b0;
            if (phase_inc >= LAST_PHASE) begin
              if (is_read_q) begin
                last_d = recv_q;
              end
              enable_d = 1'b0;
              phase_d  = '0;
              send_d   = '0;
              done_d   = 1'b1;
            end else begin
              send_d = {send_q[FRAME-2:0], 1'b0};
            end
          end
        end
      end
      default: begin
      end
    endcase
    drive_d = enable_d && (!is_read_d || phase_d < RX_PHASE);
    level_d = drive_d && send_d[FRAME-1];
  end

  assign last_wide = {{FW{1'b0}}, last_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_flag_q  <= twsbm_pkg::READ_FLAG_RST;
      write_flag_q <= twsbm_pkg::WRITE_FLAG_RST;
      phase_q      <= '0;
      is_read_q    <= 1'b0;
      send_q       <= '0;
      recv_q       <= '0;
      last_q       <= '0;
      enable_q     <= 1'b0;
      clock_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (twsbm_pkg::cfg_idx_e'(cfg_index_i))
          twsbm_pkg::CFG_READ_FLAG:  read_flag_q  <= cfg_data_i;
          twsbm_pkg::CFG_WRITE_FLAG: write_flag_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        phase_q   <= phase_d;
        is_read_q <= is_read_d;
        send_q    <= send_d;
        recv_q    <= recv_d;
        last_q    <= last_d;
        enable_q  <= enable_d;
        clock_q   <= clock_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      enable_res_q <= enable_d;
      clock_res_q  <= clock_d;
      line_res_q   <= level_d;
      drive_res_q  <= drive_d;
      done_res_q   <= done_d;
      byte_res_q   <= last_wide[FW-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign enable_out_o = enable_res_q;
  assign clock_out_o  = clock_res_q;
  assign line_out_o   = line_res_q;
  assign line_drive_o = drive_res_q;
  assign busy_res_o   = enable_res_q;
  assign done_res_o   = done_res_q;
  assign read_byte_o  = byte_res_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the three-wire serial byte master: framed traffic, flag settings, stalls.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twsbm_pkg::*;

  localparam int unsigned NB          = BYTE_BITS_DEF;
  localparam int unsigned LAST_PHASE  = 4 * NB;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_style_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] addr;
    logic [FIELD_W-1:0] wdata;
    logic               line;
  } bus_req_t;

  typedef struct packed {
    logic               enable;
    logic               clock;
    logic               line;
    logic               drive;
    logic               busy;
    logic               done;
    logic [FIELD_W-1:0] rbyte;
  } bus_levels_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    mode      = '0;
  logic [FIELD_W-1:0]   cmd_addr  = '0;
  logic [FIELD_W-1:0]   wr_data   = '0;
  logic                 line_in   = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 enable_out, clock_out, line_out, line_drive, busy_res, done_res;
  logic [FIELD_W-1:0]   read_byte;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0]   cfg_data  = '0;

  three_wire_serial_byte_master_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .mode_i            (mode),
    .command_address_i (cmd_addr),
    .write_data_i      (wr_data),
    .line_in_i         (line_in),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .enable_out_o      (enable_out),
    .clock_out_o       (clock_out),
    .line_out_o        (line_out),
    .line_drive_o      (line_drive),
    .busy_res_o        (busy_res),
    .done_res_o        (done_res),
    .read_byte_o       (read_byte),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // bus master shadow state
  logic [5:0]      m_phase   = '0;
  logic            m_is_read = 1'b0;
  logic [2*NB-1:0] m_send    = '0;
  logic [NB-1:0]   m_recv    = '0;
  logic [NB-1:0]   m_last    = '0;
  logic            m_enable  = 1'b0;
  logic            m_clock   = 1'b0;
  logic [FIELD_W-1:0] m_rflag = READ_FLAG_RST;
  logic [FIELD_W-1:0] m_wflag = WRITE_FLAG_RST;

  bus_req_t    req_q[$];
  bus_levels_t levels_q[$];
  bus_req_t    req_cur;
  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_err      = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned stall_cnt  = 0;
  stall_style_e stall_style = STALL_NONE;

  function automatic bus_levels_t step_bus(bus_req_t r);
    bus_levels_t o;
    logic        fin;
    int unsigned bitn;
    fin = 1'b0;
    if (!m_enable && (r.mode == MODE_START_READ || r.mode == MODE_START_WRITE)) begin
      m_is_read = (r.mode == MODE_START_READ);
      m_send    = {NB'(r.addr | (m_is_read ? m_rflag : m_wflag)),
                   NB'(m_is_read ? '0 : r.wdata)};
      m_recv    = '0;
      m_phase   = '0;
      m_enable  = 1'b1;
      m_clock   = 1'b0;
    end else if (m_enable && r.mode == MODE_TICK) begin
      m_phase = m_phase + 1'b1;
      if (m_phase[0]) begin
        bitn = (m_phase - 1) / 2;
        if (m_is_read && bitn >= NB) m_recv = {m_recv[NB-2:0], r.line};
        m_clock = 1'b1;
      end else begin
        m_clock = 1'b0;
        if (m_phase >= LAST_PHASE) begin
          if (m_is_read) m_last = m_recv;
          m_enable = 1'b0;
          m_phase  = '0;
          m_send   = '0;
          fin      = 1'b1;
        end else begin
          m_send = m_send << 1;
        end
      end
    end
    o.enable = m_enable;
    o.clock  = m_clock;
    o.busy   = m_enable;
    o.drive  = m_enable && (!m_is_read || (m_phase / 2) < NB);
    o.line   = o.drive ? m_send[2*NB-1] : 1'b0;
    o.done   = fin;
    o.rbyte  = FIELD_W'(m_last);
    return o;
  endfunction

  always @(posedge clk_i) begin
    logic fire;
    logic go;
    if (rst_ni) begin
      fire = in_valid && !in_stall;
      if (fire) begin
        levels_q.push_back(step_bus(req_cur));
        n_accepted++;
      end
      if (!in_valid || fire) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          req_cur = req_q.pop_front();
          go      = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid <= go;
        if (go) begin
          mode     <= req_cur.mode;
          cmd_addr <= req_cur.addr;
          wr_data  <= req_cur.wdata;
          line_in  <= req_cur.line;
        end
      end
    end
  end

  task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin
    bus_levels_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (levels_q.size() == 0) begin
          $error("result beat with nothing expected");
          n_err++;
        end else begin
          want = levels_q.pop_front();
          check_field("enable_out", want.enable, enable_out);
          check_field("clock_out", want.clock, clock_out);
          check_field("line_out", want.line, line_out);
          check_field("line_drive", want.drive, line_drive);
          check_field("busy_res", want.busy, busy_res);
          check_field("done_res", want.done, done_res);
          check_field("read_byte", want.rbyte, read_byte);
        end
      end
      stall_cnt++;
      if (stall_cnt % 97 == 0) stall_style = stall_style_e'($urandom_range(0, 3));
      case (stall_style)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
        STALL_PERIODIC: out_stall <= (stall_cnt % 3 == 0);
        default:        out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_req(logic [MODE_W-1:0] m, logic ln);
    bus_req_t r;
    r.mode  = m;
    r.addr  = FIELD_W'($urandom);
    r.wdata = FIELD_W'($urandom);
    r.line  = ln;
    req_q.push_back(r);
    n_queued++;
  endtask

  task automatic push_noise(int unsigned cnt);
    logic [MODE_W-1:0] m;
    repeat (cnt) begin
      m = ($urandom_range(0, 1) == 0) ? MODE_TICK : MODE_NOP;
      push_req(m, 1'($urandom_range(0, 1)));
    end
  endtask

  // start beat, then the ticks of one whole frame; rx is what the slave returns on a read
  task automatic push_frame(logic [MODE_W-1:0] m, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] d,
                            logic [NB-1:0] rx, int unsigned intrude_pct);
    bus_req_t    r;
    int unsigned bitn;
    logic [MODE_W-1:0] junk;
    r.mode  = m;
    r.addr  = a;
    r.wdata = d;
    r.line  = 1'($urandom_range(0, 1));
    req_q.push_back(r);
    n_queued++;
    for (int unsigned ph = 1; ph <= LAST_PHASE; ph++) begin
      if (intrude_pct > 0 && $urandom_range(0, 99) < intrude_pct) begin
        case ($urandom_range(0, 2))
          0:       junk = MODE_START_READ;
          1:       junk = MODE_START_WRITE;
          default: junk = MODE_NOP;
        endcase
        push_req(junk, 1'($urandom_range(0, 1)));
      end
      bitn = (ph - 1) / 2;
      if (ph % 2 == 1 && bitn >= NB) push_req(MODE_TICK, rx[NB-1-(bitn-NB)]);
      else push_req(MODE_TICK, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic set_cmd_flag(cfg_idx_e idx, logic [FIELD_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_READ_FLAG) m_rflag = val;
    else m_wflag = val;
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i); while (n_accepted != n_queued || levels_q.size() != 0);
  endtask

  task automatic push_random_traffic(int unsigned target);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = n_queued + target;
    while (n_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        push_frame(($urandom_range(0, 1) == 0) ? MODE_START_READ : MODE_START_WRITE,
                   FIELD_W'($urandom), FIELD_W'($urandom), NB'($urandom), 0);
      end else if (pick < 85) begin
        push_frame(($urandom_range(0, 1) == 0) ? MODE_START_READ : MODE_START_WRITE,
                   FIELD_W'($urandom), FIELD_W'($urandom), NB'($urandom), 8);
      end else begin
        push_noise($urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_req(MODE_TICK, 1'b0);
    push_req(MODE_TICK, 1'b1);
    push_req(MODE_NOP, 1'b1);
    push_frame(MODE_START_WRITE, 8'h00, 8'hFF, '0, 0);
    push_frame(MODE_START_WRITE, 8'hFF, 8'h00, '1, 0);
    push_frame(MODE_START_READ, 8'h00, 8'h00, 8'hFF, 0);
    push_frame(MODE_START_READ, 8'hFF, 8'hFF, 8'h00, 0);
    push_frame(MODE_START_READ, 8'h5A, 8'h3C, 8'hA5, 30);
    push_frame(MODE_START_WRITE, 8'h80, 8'h81, 8'h01, 30);
    wait_quiet();

    for (int unsigned pass = 0; pass < 6; pass++) begin
      case (pass)
        0: begin
          set_cmd_flag(CFG_READ_FLAG, 8'h00);
          set_cmd_flag(CFG_WRITE_FLAG, 8'hFF);
        end
        1: begin
          set_cmd_flag(CFG_READ_FLAG, 8'hFF);
          set_cmd_flag(CFG_WRITE_FLAG, 8'h00);
        end
        2: begin
          set_cmd_flag(CFG_READ_FLAG, 8'h80);
          set_cmd_flag(CFG_WRITE_FLAG, 8'h01);
        end
        default: begin
          set_cmd_flag(CFG_READ_FLAG, FIELD_W'($urandom));
          set_cmd_flag(CFG_WRITE_FLAG, FIELD_W'($urandom));
        end
      endcase
      push_random_traffic(55);
      wait_quiet();
    end

    repeat (4) @(posedge clk_i);
    if (n_err == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== three_wire_serial_byte_master_unit.f =====
rtl/core/twsbm_pkg.sv
rtl/core/three_wire_serial_byte_master_unit.sv
tb/tb.sv
